// ===== hw/rtl/q2e_pkg.sv =====
// Package for the quaternion to Euler converter: formats, CORDIC constants,
// and the arctangent table shared by q2e_cordic and the testbench. No dependencies.
`timescale 1ns / 1ps
package q2e_pkg;
    localparam int QUAT_W_DEF  = 16;
    localparam int ANGLE_W_DEF = 16;
    localparam int ITERS       = 20;
    // Q.30 products, widened for headroom
    localparam int PW          = 36;
    // CORDIC x/y datapath, extra growth bits
    localparam int CW          = 38;
    // Q.20 angle accumulator
    localparam int ZW          = 24;
    localparam logic signed [ZW-1:0] HALF_PI_Q20 = 24'sd1647099;

    function automatic logic signed [ZW-1:0] atan_tab(input int i);
        logic signed [ZW-1:0] v;
        begin
            case (i)
                0: v = 24'sd823550;  1: v = 24'sd486170;  2: v = 24'sd256879;
                3: v = 24'sd130396;  4: v = 24'sd65451;   5: v = 24'sd32757;
                6: v = 24'sd16383;   7: v = 24'sd8192;    8: v = 24'sd4096;
                9: v = 24'sd2048;    10: v = 24'sd1024;   11: v = 24'sd512;
                12: v = 24'sd256;    13: v = 24'sd128;    14: v = 24'sd64;
                15: v = 24'sd32;     16: v = 24'sd16;     17: v = 24'sd8;
                18: v = 24'sd4;      19: v = 24'sd2;
                default: v = '0;
            endcase
            return v;
        end
    endfunction
endpackage

// ===== hw/rtl/q2e_if.sv =====
// Valid/ready channel interface carrying one request payload.
// Depends on nothing; payload width set by parameter.
`timescale 1ns / 1ps
interface q2e_if #(parameter int W = 64);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/q2e_cordic.sv =====
// Pipelined vectoring CORDIC arctangent, one iteration per register stage.
// Depends on q2e_pkg. Advances when i_en is high.
`timescale 1ns / 1ps
module q2e_cordic
    import q2e_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [CW-1:0] i_y,
    input  logic signed [CW-1:0] i_x,
    output logic signed [ZW-1:0] o_z
);
    logic signed [CW-1:0] r_x [ITERS+1];
    logic signed [CW-1:0] r_y [ITERS+1];
    logic signed [ZW-1:0] r_z [ITERS+1];
    logic signed [CW-1:0] n_x0, n_y0;
    logic signed [ZW-1:0] n_z0;

    // Pre-rotate a left-half vector into the right half
    always_comb begin
        n_x0 = i_x;
        n_y0 = i_y;
        n_z0 = '0;
        if (i_x < 0) begin
            if (i_y >= 0) begin
                n_x0 = i_y;
                n_y0 = -i_x;
                n_z0 = HALF_PI_Q20;
            end else begin
                n_x0 = -i_y;
                n_y0 = i_x;
                n_z0 = -HALF_PI_Q20;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= n_x0;
            r_y[0] <= n_y0;
            r_z[0] <= n_z0;
        end
    end

    // One rotation per stage; arithmetic shift is a floor shift
    for (genvar g = 0; g < ITERS; g++) begin : g_it
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[g] >= 0) begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + atan_tab(g);
                end else begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - atan_tab(g);
                end
            end
        end
    end

    // Zero vector: no pre-rotation is taken and y starts at zero, which picks the
    // positive branch, so z does not stay zero; handled at top level.
    assign o_z = r_z[ITERS];
endmodule

// ===== hw/rtl/q2e_sqrt.sv =====
// Pipelined digit-by-digit integer square root, one result bit per stage.
// Depends on nothing else. Input at most 2^31; result 16 bits; an input
// register and 16 steps.
`timescale 1ns / 1ps
module q2e_sqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_v,
    output logic [15:0] o_root
);
    logic [31:0] r_v   [17];
    logic [31:0] r_res [17];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v[0]   <= i_v;
            r_res[0] <= '0;
        end
    end

    // Restoring step with bit = 4^(15-g)
    for (genvar g = 0; g < 16; g++) begin : g_st
        localparam logic [31:0] BIT = 32'd1 << (30 - 2*g);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_v[g] >= r_res[g] + BIT) begin
                    r_v[g+1]   <= r_v[g] - (r_res[g] + BIT);
                    r_res[g+1] <= (r_res[g] >> 1) + BIT;
                end else begin
                    r_v[g+1]   <= r_v[g];
                    r_res[g+1] <= r_res[g] >> 1;
                end
            end
        end
    end

    assign o_root = r_res[16][15:0];
endmodule

// ===== hw/rtl/quaternion_to_euler.sv =====
// Quaternion to Euler conversion: product stage, square roots, three
// CORDIC arctangents, rounding. Depends on q2e_pkg, q2e_if, q2e_cordic, q2e_sqrt.
`timescale 1ns / 1ps
// Usage:
//   i_quat (sink) takes one quaternion request {w, x, y, z}, each signed
//   QUAT_WIDTH bits Q1.(QUAT_WIDTH-1). o_angle (source) returns one request
//   {roll, pitch, yaw} in radians with ANGLE_WIDTH-3 fraction bits; pitch
//   is one bit narrower.
//   Throughput: one request per cycle when not stalled. The data passes
//   through 41 register stages (the first loads at the accepting edge):
//   2 product stages, 17 square root stages, 21 CORDIC stages and one
//   output register.
//   The whole pipeline advances as one: when the receiver holds ready low
//   with a result waiting, every stage holds and i_quat.ready drops; nothing
//   is lost or repeated. Each stage carries a valid bit.
//   Reset (i_rst_n low, synchronous) clears all valid bits; the data
//   registers and zero-vector flags are not reset.
module quaternion_to_euler
    import q2e_pkg::*;
#(
    parameter int QUAT_WIDTH  = QUAT_W_DEF,
    parameter int ANGLE_WIDTH = ANGLE_W_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    q2e_if.sink   i_quat,
    q2e_if.source o_angle
);
    localparam int DEPTH = 41;
    localparam int FB    = ANGLE_WIDTH - 3;
    localparam int SH    = 20 - FB;

    typedef logic signed [PW-1:0] t_prod;

    logic              en;
    logic [DEPTH-1:0]  r_vld;

    // Advance when the output is free or about to be taken
    assign en           = !r_vld[DEPTH-1] || o_angle.ready;
    assign i_quat.ready = en;
    assign o_angle.valid = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_quat.valid};
        end
    end

    // Bring each input to Q1.15
    function automatic logic signed [16:0] load_q(input logic [QUAT_WIDTH-1:0] raw);
        logic signed [QUAT_WIDTH-1:0] v;
        begin
            v = raw;
            if (QUAT_WIDTH >= 16)
                return 17'(v >>> (QUAT_WIDTH - 16));
            else
                return 17'(v) <<< (16 - QUAT_WIDTH);
        end
    endfunction

    logic signed [16:0] qw, qx, qy, qz;
    assign qw = load_q(i_quat.data[4*QUAT_WIDTH-1 -: QUAT_WIDTH]);
    assign qx = load_q(i_quat.data[3*QUAT_WIDTH-1 -: QUAT_WIDTH]);
    assign qy = load_q(i_quat.data[2*QUAT_WIDTH-1 -: QUAT_WIDTH]);
    assign qz = load_q(i_quat.data[QUAT_WIDTH-1 -: QUAT_WIDTH]);

    // Stage 1: all pairwise products
    t_prod r_wx, r_yz, r_xx, r_yy, r_zz, r_wy, r_xz, r_wz, r_xy;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wx <= PW'(qw * qx);  r_yz <= PW'(qy * qz);
            r_xx <= PW'(qx * qx);  r_yy <= PW'(qy * qy);
            r_zz <= PW'(qz * qz);  r_wy <= PW'(qw * qy);
            r_xz <= PW'(qx * qz);  r_wz <= PW'(qw * qz);
            r_xy <= PW'(qx * qy);
        end
    end

    // Stage 2: sums, differences, clamp of the pitch term
    localparam t_prod ONE = t_prod'(1) <<< 30;
    t_prod r_sr, r_cr, r_sy, r_cy;
    logic [31:0] r_tp, r_tm;
    t_prod n_t;
    always_comb begin
        n_t = (r_wy - r_xz) <<< 1;
        if (n_t > ONE)  n_t = ONE;
        if (n_t < -ONE) n_t = -ONE;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sr <= (r_wx + r_yz) <<< 1;
            r_cr <= ONE - ((r_xx + r_yy) <<< 1);
            r_sy <= (r_wz + r_xy) <<< 1;
            r_cy <= ONE - ((r_yy + r_zz) <<< 1);
            r_tp <= 32'(ONE + n_t);
            r_tm <= 32'(ONE - n_t);
        end
    end

    // Square roots (17 stages); delay roll/yaw operands alongside
    logic [15:0] rt_p, rt_m;
    q2e_sqrt u_sqp (.i_clk(i_clk), .i_en(en), .i_v(r_tp), .o_root(rt_p));
    q2e_sqrt u_sqm (.i_clk(i_clk), .i_en(en), .i_v(r_tm), .o_root(rt_m));

    t_prod r_d_sr [17];
    t_prod r_d_cr [17];
    t_prod r_d_sy [17];
    t_prod r_d_cy [17];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_sr[0] <= r_sr; r_d_cr[0] <= r_cr;
            r_d_sy[0] <= r_sy; r_d_cy[0] <= r_cy;
            for (int k = 1; k < 17; k++) begin
                r_d_sr[k] <= r_d_sr[k-1]; r_d_cr[k] <= r_d_cr[k-1];
                r_d_sy[k] <= r_d_sy[k-1]; r_d_cy[k] <= r_d_cy[k-1];
            end
        end
    end

    // Arctangents (21 stages), zero-vector flags carried alongside
    logic signed [CW-1:0] a_sp, a_cp;
    assign a_sp = CW'({1'b0, rt_p}) <<< 15;
    assign a_cp = CW'({1'b0, rt_m}) <<< 15;

    logic signed [ZW-1:0] z_r, z_p, z_y;
    q2e_cordic u_atr (.i_clk(i_clk), .i_en(en), .i_y(CW'(r_d_sr[16])),
                      .i_x(CW'(r_d_cr[16])), .o_z(z_r));
    q2e_cordic u_atp (.i_clk(i_clk), .i_en(en), .i_y(a_sp), .i_x(a_cp), .o_z(z_p));
    q2e_cordic u_aty (.i_clk(i_clk), .i_en(en), .i_y(CW'(r_d_sy[16])),
                      .i_x(CW'(r_d_cy[16])), .o_z(z_y));

    logic [20:0] r_zr_z, r_zy_z, r_zp_z;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zr_z <= {r_zr_z[19:0], (r_d_sr[16] == 0) && (r_d_cr[16] == 0)};
            r_zy_z <= {r_zy_z[19:0], (r_d_sy[16] == 0) && (r_d_cy[16] == 0)};
            r_zp_z <= {r_zp_z[19:0], (rt_p == 0) && (rt_m == 0)};
        end
    end

    // Round to output scale and saturate
    localparam int AW = ZW + 2 + ((SH < 0) ? -SH : 0);
    typedef logic signed [AW-1:0] t_ang;
    function automatic t_ang to_angle(input t_ang z);
        begin
            if (SH > 0)
                return (z + (t_ang'(1) <<< (SH - 1))) >>> SH;
            else
                return z <<< (-SH);
        end
    endfunction
    function automatic t_ang sat(input t_ang v, input t_ang lim);
        begin
            if (v > lim)  return lim;
            if (v < -lim) return -lim;
            return v;
        end
    endfunction

    localparam t_ang PI_OUT  = to_angle(t_ang'(3294199));
    localparam t_ang HPI_OUT = to_angle(t_ang'(1647099));

    t_ang zr_e, zp_e, zy_e;
    assign zr_e = r_zr_z[20] ? t_ang'(0) : t_ang'(z_r);
    assign zy_e = r_zy_z[20] ? t_ang'(0) : t_ang'(z_y);
    assign zp_e = ((r_zp_z[20] ? t_ang'(0) : t_ang'(z_p)) <<< 1) - t_ang'(HALF_PI_Q20);

    logic [ANGLE_WIDTH-1:0] r_roll, r_yaw;
    logic [ANGLE_WIDTH-2:0] r_pitch;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_roll  <= ANGLE_WIDTH'(sat(to_angle(zr_e), PI_OUT));
            r_pitch <= (ANGLE_WIDTH-1)'(sat(to_angle(zp_e), HPI_OUT));
            r_yaw   <= ANGLE_WIDTH'(sat(to_angle(zy_e), PI_OUT));
        end
    end

    assign o_angle.data = {r_roll, r_pitch, r_yaw};

`ifndef NO_ASSERTIONS
    // A waiting result stays put while the receiver stalls
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_angle.valid && !o_angle.ready |=> o_angle.valid && $stable(o_angle.data))
        else $error("result changed under stall");
    // Input is refused only while the output is blocked
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_quat.ready |-> o_angle.valid && !o_angle.ready)
        else $error("input stalled without output backpressure");
    // Pitch stays within half pi
    a_pitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_angle.valid |-> ($signed(r_pitch) <= HPI_OUT) && ($signed(r_pitch) >= -HPI_OUT))
        else $error("pitch out of range");
`endif
endmodule

// ===== verif/tb_quaternion_to_euler.sv =====
// Testbench for quaternion_to_euler: drives quaternion requests through the
// valid/ready channel and checks roll, pitch and yaw against a bit-exact
// fixed-point predictor. Depends on q2e_pkg, q2e_if and the block's RTL.
`timescale 1ns / 1ps
module tb_quaternion_to_euler;
    import q2e_pkg::*;

    localparam int QW = QUAT_W_DEF;
    localparam int AW = ANGLE_W_DEF;
    localparam int DW = 4 * QW;
    localparam int RW = 3 * AW - 1;
    localparam int LATENCY = 41;
    localparam longint PI_Q20_EXACT = 64'sd3294199;
    localparam longint HPI_Q20 = 64'sd1647099;

    typedef struct packed {
        logic signed [QW-1:0] w;
        logic signed [QW-1:0] x;
        logic signed [QW-1:0] y;
        logic signed [QW-1:0] z;
    } t_quat;

    typedef struct packed {
        logic signed [AW-1:0] roll;
        logic signed [AW-2:0] pitch;
        logic signed [AW-1:0] yaw;
    } t_euler;

    // Directed row: quaternion plus an optional hand-typed expectation
    typedef struct {
        t_quat  q;
        bit     known;
        t_euler e;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    q2e_if #(.W(DW)) quat_ch ();
    q2e_if #(.W(RW)) angle_ch ();

    quaternion_to_euler i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_quat  (quat_ch.sink),
        .o_angle (angle_ch.source)
    );

    t_euler angles_due[$];
    int     n_err;
    int     n_sent;
    int     n_got;
    int     send_idle_pct;
    int     recv_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #100ms;
        $display("status: fail");
        $finish;
    end

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    // Vectoring CORDIC, Q.20 radians
    function automatic longint cordic_angle(longint y, longint x);
        longint z;
        longint t;
        longint dx;
        longint dy;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = HPI_Q20;
            end else begin
                x = -y;
                y = t;
                z = -HPI_Q20;
            end
        end
        for (int i = 0; i < ITERS; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (y >= 0) begin
                x += dx;
                y -= dy;
                z += longint'(atan_tab(i));
            end else begin
                x -= dx;
                y += dy;
                z -= longint'(atan_tab(i));
            end
        end
        return z;
    endfunction

    // Round Q.20 to output fraction, half up
    function automatic longint round_angle(longint z);
        int s;
        s = 20 - (AW - 3);
        return floor_shr(z + (64'sd1 <<< (s - 1)), s);
    endfunction

    function automatic longint clip(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic t_euler predict_euler(t_quat q);
        longint one;
        longint w;
        longint x;
        longint y;
        longint z;
        longint t;
        longint sp;
        longint cp;
        longint pi_o;
        longint hpi_o;
        t_euler e;
        one = 64'sd1 <<< 30;
        w = q.w;
        x = q.x;
        y = q.y;
        z = q.z;
        pi_o = round_angle(PI_Q20_EXACT);
        hpi_o = round_angle(HPI_Q20);
        e.roll = AW'(clip(round_angle(cordic_angle(2 * (w * x + y * z),
                     one - 2 * (x * x + y * y))), pi_o));
        t = 2 * (w * y - x * z);
        if (t > one) t = one;
        if (t < -one) t = -one;
        sp = int_sqrt(longint'(one + t)) <<< 15;
        cp = int_sqrt(longint'(one - t)) <<< 15;
        e.pitch = (AW-1)'(clip(round_angle(2 * cordic_angle(sp, cp) - HPI_Q20), hpi_o));
        e.yaw = AW'(clip(round_angle(cordic_angle(2 * (w * z + x * y),
                    one - 2 * (y * y + z * z))), pi_o));
        return e;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, n_got);
        n_err++;
    endtask

    // Send one request, idling first at the phase's rate
    task automatic send_quat(t_quat q, t_euler e);
        while ($urandom_range(99) < send_idle_pct) begin
            quat_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        quat_ch.valid <= 1'b1;
        quat_ch.data  <= q;
        angles_due.push_back(e);
        @(posedge i_clk);
        while (!quat_ch.ready) @(posedge i_clk);
        n_sent++;
    endtask

    function automatic t_quat rand_quat();
        t_quat q;
        int mode;
        mode = $urandom_range(9);
        q = {$urandom, $urandom};
        // Mostly random quaternions with each component shifted down by 0 to 3 bits
        if (mode < 6) begin
            q.w = $signed(q.w) >>> $urandom_range(3);
            q.x = $signed(q.x) >>> $urandom_range(3);
            q.y = $signed(q.y) >>> $urandom_range(3);
            q.z = $signed(q.z) >>> $urandom_range(3);
        end else if (mode == 6) begin
            q.x = 0;
            q.z = 0;
        end
        return q;
    endfunction

    // Drain results and compare with oldest expectation
    always @(posedge i_clk) begin
        t_euler got;
        t_euler want;
        if (i_rst_n && angle_ch.valid && angle_ch.ready) begin
            got = angle_ch.data;
            n_got++;
            if (angles_due.size() == 0) begin
                $display("unexpected result %0d", n_got);
                n_err++;
            end else begin
                want = angles_due.pop_front();
                if (got.roll !== want.roll) report_mismatch("roll", got.roll, want.roll);
                if (got.pitch !== want.pitch)
                    report_mismatch("pitch", got.pitch, want.pitch);
                if (got.yaw !== want.yaw) report_mismatch("yaw", got.yaw, want.yaw);
            end
        end
        angle_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        t_row   rows[$];
        t_row   r;
        t_quat  q;
        int     wait_cyc;
        localparam logic signed [QW-1:0] MX = {1'b0, {(QW-1){1'b1}}};
        localparam logic signed [QW-1:0] MN = {1'b1, {(QW-1){1'b0}}};
        n_err = 0;
        n_sent = 0;
        n_got = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        quat_ch.valid = 1'b0;
        quat_ch.data = '0;
        angle_ch.ready = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Identity and zero quaternion give all-zero angles
        r.known = 1; r.e = '0;
        r.q = '{w: MX, x: 0, y: 0, z: 0}; rows.push_back(r);
        r.q = '0; rows.push_back(r);
        r.known = 0;
        // Pitch term saturating both ways, extremes, negative-x atan cases
        r.q = '{w: MX, x: 0, y: MX, z: 0}; rows.push_back(r);
        r.q = '{w: MX, x: 0, y: MN, z: 0}; rows.push_back(r);
        r.q = '{w: MN, x: MN, y: MN, z: MN}; rows.push_back(r);
        r.q = '{w: MX, x: MX, y: MX, z: MX}; rows.push_back(r);
        r.q = '{w: MN, x: MX, y: MN, z: MX}; rows.push_back(r);
        r.q = '{w: 0, x: MX, y: 0, z: 0}; rows.push_back(r);
        r.q = '{w: 0, x: 0, y: 0, z: MX}; rows.push_back(r);
        r.q = '{w: 0, x: 0, y: MN, z: 0}; rows.push_back(r);
        r.q = '{w: 23170, x: 23170, y: 0, z: 0}; rows.push_back(r);
        r.q = '{w: 23170, x: 0, y: 23170, z: 0}; rows.push_back(r);
        r.q = '{w: 23170, x: 0, y: 0, z: -23170}; rows.push_back(r);
        r.q = '{w: 16384, x: 16384, y: 16384, z: 16384}; rows.push_back(r);
        r.q = '{w: -1, x: -1, y: -1, z: -1}; rows.push_back(r);
        r.q = '{w: 1, x: 1, y: 1, z: 1}; rows.push_back(r);
        foreach (rows[i]) begin
            send_quat(rows[i].q, rows[i].known ? rows[i].e : predict_euler(rows[i].q));
        end

        // Random phases: free, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 54 : (ph == 3) ? 8 : 0;
            recv_stall_pct = (ph == 2) ? 54 : (ph == 3) ? 8 : 0;
            for (int k = 0; k < 500; k++) begin
                q = rand_quat();
                send_quat(q, predict_euler(q));
            end
        end
        quat_ch.valid <= 1'b0;

        // Drain, then let the pipeline settle
        wait_cyc = 0;
        while (angles_due.size() != 0 && wait_cyc < 100000) begin
            @(posedge i_clk);
            wait_cyc++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("sent %0d quaternions, checked %0d angle triples over four handshake phases",
                 n_sent, n_got);
        if (n_err == 0 && angles_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
